// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the keyword lexer. They expect clk_i and rst_ni
// to be in scope where they are used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KLL_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KLL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/kll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword lexer package
// Token kinds, scan modes, character codes, the token record and the
// keyword trie used by the lexer datapath.
// ----------------------------------------------------------------------------
package kll_pkg;

  localparam int TOK_POS_W = 16;
  localparam int TOK_LEN_W = 16;
  localparam int TOK_VAL_W = 32;

  typedef logic [4:0] kind_t;

  localparam kind_t KIND_END     = 5'd0;
  localparam kind_t KIND_INT     = 5'd1;
  localparam kind_t KIND_BEGIN   = 5'd2;
  localparam kind_t KIND_KW_END  = 5'd3;
  localparam kind_t KIND_IF      = 5'd4;
  localparam kind_t KIND_ELSE    = 5'd5;
  localparam kind_t KIND_THEN    = 5'd6;
  localparam kind_t KIND_WHILE   = 5'd7;
  localparam kind_t KIND_DO      = 5'd8;
  localparam kind_t KIND_NUMBER  = 5'd9;
  localparam kind_t KIND_PLUS    = 5'd10;
  localparam kind_t KIND_STAR    = 5'd11;
  localparam kind_t KIND_LT      = 5'd12;
  localparam kind_t KIND_GT      = 5'd13;
  localparam kind_t KIND_LE      = 5'd14;
  localparam kind_t KIND_GE      = 5'd15;
  localparam kind_t KIND_NE      = 5'd16;
  localparam kind_t KIND_EQEQ    = 5'd17;
  localparam kind_t KIND_COMMA   = 5'd18;
  localparam kind_t KIND_SEMI    = 5'd19;
  localparam kind_t KIND_LPAREN  = 5'd20;
  localparam kind_t KIND_RPAREN  = 5'd21;
  localparam kind_t KIND_ASSIGN  = 5'd22;
  localparam kind_t KIND_IDENT   = 5'd23;
  localparam kind_t KIND_BADWORD = 5'd24;
  localparam kind_t KIND_ILLEGAL = 5'd25;
  localparam kind_t KIND_BANG    = 5'd26;

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_WORD   = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_IDENT  = 3'd3;
  localparam logic [2:0] MODE_SYMBOL = 3'd4;

  localparam logic [1:0] SYM_LT   = 2'd0;
  localparam logic [1:0] SYM_GT   = 2'd1;
  localparam logic [1:0] SYM_BANG = 2'd2;
  localparam logic [1:0] SYM_EQ   = 2'd3;

  localparam logic [4:0] NODE_ROOT = 5'd0;
  localparam logic [4:0] NODE_DEAD = 5'd31;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;

  typedef struct packed {
    kind_t                kind;
    logic [TOK_POS_W-1:0] start;
    logic [TOK_LEN_W-1:0] length;
    logic [TOK_VAL_W-1:0] value;
    logic                 overflow;
    logic                 last;
  } tok_t;

  // Up to two tokens from one byte: a flushed pending token, then its own.
  typedef struct packed {
    tok_t       t0;
    tok_t       t1;
    logic [1:0] cnt;
  } tok_pair_t;

  typedef struct packed {
    logic [4:0] node;
    kind_t      kind;
  } trie_t;

  function automatic logic letter_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic kind_t single_kind(input logic [1:0] sym);
    case (sym)
      SYM_LT:   return KIND_LT;
      SYM_GT:   return KIND_GT;
      SYM_BANG: return KIND_BANG;
      default:  return KIND_ASSIGN;
    endcase
  endfunction

  function automatic kind_t double_kind(input logic [1:0] sym);
    case (sym)
      SYM_LT:   return KIND_LE;
      SYM_GT:   return KIND_GE;
      SYM_BANG: return KIND_NE;
      default:  return KIND_EQEQ;
    endcase
  endfunction

  // One step through the keyword trie. A nonzero kind means the edge
  // completes that keyword and the walk returns to the root.
  function automatic trie_t trie_step(input logic [4:0] node, input logic [7:0] c);
    trie_t r;
    r.node = NODE_DEAD;
    r.kind = KIND_END;
    case ({node, c})
      {5'd0,  8'("i")}: r.node = 5'd1;
      {5'd1,  8'("n")}: r.node = 5'd2;
      {5'd2,  8'("t")}: begin r.node = NODE_ROOT; r.kind = KIND_INT; end
      {5'd1,  8'("f")}: begin r.node = NODE_ROOT; r.kind = KIND_IF; end
      {5'd0,  8'("b")}: r.node = 5'd3;
      {5'd3,  8'("e")}: r.node = 5'd4;
      {5'd4,  8'("g")}: r.node = 5'd5;
      {5'd5,  8'("i")}: r.node = 5'd6;
      {5'd6,  8'("n")}: begin r.node = NODE_ROOT; r.kind = KIND_BEGIN; end
      {5'd0,  8'("e")}: r.node = 5'd7;
      {5'd7,  8'("n")}: r.node = 5'd8;
      {5'd8,  8'("d")}: begin r.node = NODE_ROOT; r.kind = KIND_KW_END; end
      {5'd7,  8'("l")}: r.node = 5'd9;
      {5'd9,  8'("s")}: r.node = 5'd10;
      {5'd10, 8'("e")}: begin r.node = NODE_ROOT; r.kind = KIND_ELSE; end
      {5'd0,  8'("t")}: r.node = 5'd11;
      {5'd11, 8'("h")}: r.node = 5'd12;
      {5'd12, 8'("e")}: r.node = 5'd13;
      {5'd13, 8'("n")}: begin r.node = NODE_ROOT; r.kind = KIND_THEN; end
      {5'd0,  8'("w")}: r.node = 5'd14;
      {5'd14, 8'("h")}: r.node = 5'd15;
      {5'd15, 8'("i")}: r.node = 5'd16;
      {5'd16, 8'("l")}: r.node = 5'd17;
      {5'd17, 8'("e")}: begin r.node = NODE_ROOT; r.kind = KIND_WHILE; end
      {5'd0,  8'("d")}: r.node = 5'd18;
      {5'd18, 8'("o")}: begin r.node = NODE_ROOT; r.kind = KIND_DO; end
      default:          r.node = NODE_DEAD;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/kll_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword lexer channel interfaces
// Valid/ready channels for source bytes and for finished tokens.
// ----------------------------------------------------------------------------
interface kll_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface kll_token_if
  import kll_pkg::*;
;
  logic                 valid;
  logic                 ready;
  kind_t                token_kind;
  logic [TOK_POS_W-1:0] token_start;
  logic [TOK_LEN_W-1:0] token_length;
  logic [TOK_VAL_W-1:0] number_value;
  logic                 number_overflow;
  logic                 last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output number_value,
                  output number_overflow, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input number_value,
                input number_overflow, input last_of_run, output ready);
endinterface

// ===== rtl/core/keyword_lexer_tokenizer_core.sv =====
`timescale 1ns / 1ps
// A taken byte is lexed from the input register; its tokens are loaded into the result
// register, which presents them on the output. Throughput: one byte per cycle while each
// byte yields at most one token and the output is ready; after a two-token byte, the next
// byte waits in the input register while the first token is taken, as the result register
// presents one token per cycle. Reset (rst_ni low, asynchronous) empties both registers,
// returns the scanner to idle and clears the byte offset; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Keyword lexer core
// Streaming tokenizer: one source byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyword_lexer_tokenizer_core
  import kll_pkg::*;
#(
  parameter int POSITION_BITS = 16,
  parameter int NUMBER_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kll_byte_if.sink    byte_in_i,
  kll_token_if.source token_out_o
);

  localparam int PW = POSITION_BITS;
  localparam int NW = NUMBER_BITS;

  logic [7:0]    byte_q;
  logic          byte_vq;
  logic          advance;
  logic          buf_free;
  tok_pair_t     pair;

  logic [2:0]    mode_q, mode_d;
  logic [4:0]    node_q, node_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] start_q, start_d;
  logic [PW-1:0] len_q, len_d;
  logic [NW-1:0] acc_q, acc_d;
  logic          ovf_q, ovf_d;
  logic [1:0]    psym_q, psym_d;

  assign advance         = byte_vq && buf_free;
  assign byte_in_i.ready = !byte_vq || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vq <= 1'b0;
    end else if (byte_in_i.ready) begin
      byte_vq <= byte_in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_in_i.valid && byte_in_i.ready) begin
      byte_q <= byte_in_i.char_in;
    end
  end

  kll_lex_step #(
    .PW (PW),
    .NW (NW)
  ) u_step (
    .byte_i  (byte_q),
    .mode_i  (mode_q),
    .node_i  (node_q),
    .pos_i   (pos_q),
    .start_i (start_q),
    .len_i   (len_q),
    .acc_i   (acc_q),
    .ovf_i   (ovf_q),
    .psym_i  (psym_q),
    .mode_o  (mode_d),
    .node_o  (node_d),
    .pos_o   (pos_d),
    .start_o (start_d),
    .len_o   (len_d),
    .acc_o   (acc_d),
    .ovf_o   (ovf_d),
    .psym_o  (psym_d),
    .pair_o  (pair)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      node_q  <= NODE_ROOT;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      psym_q  <= SYM_LT;
    end else if (advance) begin
      mode_q  <= mode_d;
      node_q  <= node_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      psym_q  <= psym_d;
    end
  end

  kll_tok_buf u_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance),
    .pair_i (pair),
    .free_o (buf_free),
    .tok_o  (token_out_o)
  );

  `KLL_ASSERT_NEXT(a_end_restarts, advance && byte_q == CH_HASH,
    pos_q == '0 && mode_q == MODE_IDLE,
    "The end mark must restart the scanner at offset zero.")
  `KLL_ASSERT_IMPLIES(a_idle_empty, mode_q == MODE_IDLE, len_q == '0,
    "An idle scanner must hold no pending run.")
  `KLL_ASSERT_NEXT(a_byte_held, byte_vq && !advance, byte_vq && $stable(byte_q),
    "A stalled byte must stay in the input register.")

endmodule

// ===== rtl/core/kll_lex_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword lexer step logic
// Next scan state and the zero to two tokens caused by one source byte.
// ----------------------------------------------------------------------------
module kll_lex_step
  import kll_pkg::*;
#(
  parameter int PW = 16,
  parameter int NW = 32
) (
  input  logic [7:0]    byte_i,
  input  logic [2:0]    mode_i,
  input  logic [4:0]    node_i,
  input  logic [PW-1:0] pos_i,
  input  logic [PW-1:0] start_i,
  input  logic [PW-1:0] len_i,
  input  logic [NW-1:0] acc_i,
  input  logic          ovf_i,
  input  logic [1:0]    psym_i,
  output logic [2:0]    mode_o,
  output logic [4:0]    node_o,
  output logic [PW-1:0] pos_o,
  output logic [PW-1:0] start_o,
  output logic [PW-1:0] len_o,
  output logic [NW-1:0] acc_o,
  output logic          ovf_o,
  output logic [1:0]    psym_o,
  output tok_pair_t     pair_o
);

  localparam int SW = (PW < TOK_POS_W) ? PW : TOK_POS_W;
  localparam int VW = (NW < TOK_VAL_W) ? NW : TOK_VAL_W;

  function automatic tok_t mk_tok(input kind_t kind, input logic [PW-1:0] start,
                                  input logic [PW-1:0] len, input logic [NW-1:0] val,
                                  input logic ovf);
    tok_t t;
    t.kind     = kind;
    t.start    = TOK_POS_W'(start[SW-1:0]);
    t.length   = ((len >> SW) != '0) ? '1 : TOK_LEN_W'(len[SW-1:0]);
    t.value    = TOK_VAL_W'(val[VW-1:0]);
    t.overflow = ovf;
    t.last     = 1'b0;
    return t;
  endfunction

  trie_t         tr_cur;
  trie_t         tr_root;
  logic [3:0]    dig;
  logic [NW+3:0] prod;
  logic [PW-1:0] len_inc;
  logic          fl_avail;
  logic          fl_v;
  logic          own_v;
  tok_t          fl_tok;
  tok_t          own_tok;
  logic          relex;
  logic          go_idle;

  assign tr_cur  = trie_step(node_i, byte_i);
  assign tr_root = trie_step(NODE_ROOT, byte_i);
  assign dig     = byte_i[3:0];
  assign len_inc = (len_i == '1) ? len_i : len_i + 1'b1;
  // Saturation test: acc * 10 + digit does not fit in NW bits.
  assign prod    = ({4'b0, acc_i} << 3) + ({4'b0, acc_i} << 1) + (NW+4)'(dig);

  // Token for whatever is pending, as ended by a byte that cannot extend it.
  always_comb begin
    fl_avail = 1'b1;
    case (mode_i)
      MODE_WORD:   fl_tok = mk_tok(KIND_BADWORD, start_i, len_i, '0, 1'b0);
      MODE_NUMBER: fl_tok = mk_tok(KIND_NUMBER, start_i, len_i, acc_i, ovf_i);
      MODE_IDENT:  fl_tok = mk_tok(KIND_IDENT, start_i, len_i, '0, 1'b0);
      MODE_SYMBOL: fl_tok = mk_tok(single_kind(psym_i), start_i, PW'(1), '0, 1'b0);
      default: begin
        fl_avail = 1'b0;
        fl_tok   = '0;
      end
    endcase
  end

  always_comb begin
    mode_o  = mode_i;
    node_o  = node_i;
    pos_o   = pos_i + 1'b1;
    start_o = start_i;
    len_o   = len_i;
    acc_o   = acc_i;
    ovf_o   = ovf_i;
    psym_o  = psym_i;
    fl_v    = 1'b0;
    own_v   = 1'b0;
    own_tok = mk_tok(KIND_END, pos_i, PW'(1), '0, 1'b0);
    relex   = 1'b0;
    go_idle = 1'b0;

    if (byte_i == CH_HASH) begin
      // End mark: flush, report the end token, then restart from reset.
      fl_v    = fl_avail;
      own_v   = 1'b1;
      mode_o  = MODE_IDLE;
      node_o  = NODE_ROOT;
      pos_o   = '0;
      start_o = '0;
      len_o   = '0;
      acc_o   = '0;
      ovf_o   = 1'b0;
      psym_o  = SYM_LT;
    end else begin
      case (mode_i)
        MODE_SYMBOL: begin
          if (byte_i == CH_EQ) begin
            own_v   = 1'b1;
            own_tok = mk_tok(double_kind(psym_i), start_i, PW'(2), '0, 1'b0);
            go_idle = 1'b1;
          end else begin
            fl_v  = 1'b1;
            relex = 1'b1;
          end
        end
        MODE_WORD: begin
          if (letter_ch(byte_i)) begin
            if (tr_cur.kind != KIND_END) begin
              own_v   = 1'b1;
              own_tok = mk_tok(tr_cur.kind, start_i, len_inc, '0, 1'b0);
              go_idle = 1'b1;
            end else begin
              node_o = tr_cur.node;
              len_o  = len_inc;
            end
          end else begin
            fl_v  = 1'b1;
            relex = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (digit_ch(byte_i)) begin
            if (prod[NW+3:NW] != '0) begin
              acc_o = '1;
              ovf_o = 1'b1;
            end else begin
              acc_o = prod[NW-1:0];
            end
            len_o = len_inc;
          end else begin
            fl_v  = 1'b1;
            relex = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (letter_ch(byte_i) || digit_ch(byte_i)) begin
            len_o = len_inc;
          end else begin
            fl_v  = 1'b1;
            relex = 1'b1;
          end
        end
        default: relex = 1'b1;
      endcase

      if (go_idle || relex) begin
        mode_o = MODE_IDLE;
        node_o = NODE_ROOT;
        len_o  = '0;
        acc_o  = '0;
        ovf_o  = 1'b0;
        psym_o = SYM_LT;
      end

      // The byte starts a new token, or is skipped.
      if (relex) begin
        if (byte_i == CH_SPACE || byte_i == CH_LF || byte_i == CH_TAB) begin
          own_v = 1'b0;
        end else if (letter_ch(byte_i)) begin
          start_o = pos_i;
          if (tr_root.kind != KIND_END) begin
            own_v   = 1'b1;
            own_tok = mk_tok(tr_root.kind, pos_i, PW'(1), '0, 1'b0);
          end else begin
            mode_o = MODE_WORD;
            node_o = tr_root.node;
            len_o  = PW'(1);
          end
        end else if (digit_ch(byte_i)) begin
          mode_o  = MODE_NUMBER;
          start_o = pos_i;
          len_o   = PW'(1);
          acc_o   = NW'(dig);
        end else if (byte_i == CH_DOLLAR) begin
          mode_o  = MODE_IDENT;
          start_o = pos_i;
          len_o   = PW'(1);
        end else if (byte_i == CH_LT || byte_i == CH_GT || byte_i == CH_BANG ||
                     byte_i == CH_EQ) begin
          mode_o  = MODE_SYMBOL;
          start_o = pos_i;
          len_o   = PW'(1);
          psym_o  = (byte_i == CH_LT) ? SYM_LT :
                    (byte_i == CH_GT) ? SYM_GT :
                    (byte_i == CH_BANG) ? SYM_BANG : SYM_EQ;
        end else begin
          own_v = 1'b1;
          case (byte_i)
            CH_PLUS:   own_tok = mk_tok(KIND_PLUS, pos_i, PW'(1), '0, 1'b0);
            CH_STAR:   own_tok = mk_tok(KIND_STAR, pos_i, PW'(1), '0, 1'b0);
            CH_COMMA:  own_tok = mk_tok(KIND_COMMA, pos_i, PW'(1), '0, 1'b0);
            CH_SEMI:   own_tok = mk_tok(KIND_SEMI, pos_i, PW'(1), '0, 1'b0);
            CH_LPAREN: own_tok = mk_tok(KIND_LPAREN, pos_i, PW'(1), '0, 1'b0);
            CH_RPAREN: own_tok = mk_tok(KIND_RPAREN, pos_i, PW'(1), '0, 1'b0);
            default:   own_tok = mk_tok(KIND_ILLEGAL, pos_i, PW'(1), '0, 1'b0);
          endcase
        end
      end
    end
  end

  always_comb begin
    pair_o.cnt     = 2'(fl_v) + 2'(own_v);
    pair_o.t0      = fl_v ? fl_tok : own_tok;
    pair_o.t0.last = !(fl_v && own_v);
    pair_o.t1      = own_tok;
    pair_o.t1.last = 1'b1;
  end

endmodule

// ===== rtl/core/kll_tok_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword lexer result register
// Holds the tokens of one byte and presents them one per cycle while the sink is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kll_tok_buf
  import kll_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  tok_pair_t  pair_i,
  output logic       free_o,
  kll_token_if.source tok_o
);

  tok_t       slot0_q, slot0_d;
  tok_t       slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       fire;

  assign fire   = tok_o.valid && tok_o.ready;
  // A new pair may load while the last held token is being taken.
  assign free_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && fire);

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      slot0_d = pair_i.t0;
      slot1_d = pair_i.t1;
      cnt_d   = pair_i.cnt;
    end else if (fire) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign tok_o.valid           = cnt_q != 2'd0;
  assign tok_o.token_kind      = slot0_q.kind;
  assign tok_o.token_start     = slot0_q.start;
  assign tok_o.token_length    = slot0_q.length;
  assign tok_o.number_value    = slot0_q.value;
  assign tok_o.number_overflow = slot0_q.overflow;
  assign tok_o.last_of_run     = slot0_q.last;

  `KLL_ASSERT_NEXT(a_pair_drain, fire && cnt_q == 2'd2, cnt_q == 2'd1,
    "Taking the first of two tokens must leave exactly one.")
  `KLL_ASSERT_IMPLIES(a_single_last, cnt_q == 2'd1, slot0_q.last,
    "A lone held token must close its byte's run.")
  `KLL_ASSERT_IMPLIES(a_pair_last, cnt_q == 2'd2, !slot0_q.last && slot1_q.last,
    "Only the second of a pair may close its byte's run.")

endmodule
